@@ hdl/qpds_pkg.sv @@
`timescale 1ns / 1ps

package qpds_pkg;

  localparam int FIFO_DEPTH = 2;
  localparam int NUM_SLOTS  = 8;

  // Output slot order for one input word
  localparam int SLOT_SP    = 0;  // ' ' or '='
  localparam int SLOT_SP_HI = 1;  // '2' of =20
  localparam int SLOT_SP_LO = 2;  // '0' of =20
  localparam int SLOT_B0    = 3;
  localparam int SLOT_B1    = 4;
  localparam int SLOT_B2    = 5;
  localparam int SLOT_CR    = 6;
  localparam int SLOT_LF    = 7;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_TWO   = 8'h32;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] PRINT_LO   = 8'd33;
  localparam logic [7:0] PRINT_HI   = 8'd126;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic                 sp_hex;
    logic [7:0]           b0;
    logic [7:0]           b1;
    logic [7:0]           b2;
  } cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = HEX_DIGITS[nib];
  endfunction

endpackage

@@ hdl/qpds_fifo.sv @@
`timescale 1ns / 1ps

module qpds_fifo #(
  parameter int Depth = qpds_pkg::FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  qpds_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output qpds_pkg::cmd_t data_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  qpds_pkg::cmd_t mem_q [Depth];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hdl/qpds_front.sv @@
`timescale 1ns / 1ps

module qpds_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     in_byte_i,
  input  logic           in_last_i,
  output logic           push_o,
  output qpds_pkg::cmd_t cmd_o,
  input  logic           full_i
);

  logic line_start_q, line_start_d;
  logic held_space_q, held_space_d;
  logic accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && (cmd_o.mask != '0);

  always_comb begin
    logic ls;
    logic is_crlf;
    logic printable;
    ls           = line_start_q;
    is_crlf      = (in_byte_i == qpds_pkg::CHAR_CR) || (in_byte_i == qpds_pkg::CHAR_LF);
    printable    = (in_byte_i >= qpds_pkg::PRINT_LO) && (in_byte_i <= qpds_pkg::PRINT_HI)
                   && (in_byte_i != qpds_pkg::CHAR_EQ);
    cmd_o        = '0;
    held_space_d = 1'b0;

    // resolve a space held from the previous word
    if (held_space_q) begin
      cmd_o.mask[qpds_pkg::SLOT_SP] = 1'b1;
      if (is_crlf) begin
        cmd_o.sp_hex                     = 1'b1;
        cmd_o.mask[qpds_pkg::SLOT_SP_HI] = 1'b1;
        cmd_o.mask[qpds_pkg::SLOT_SP_LO] = 1'b1;
      end else begin
        ls = 1'b0;
      end
    end

    if (printable && !((in_byte_i == qpds_pkg::CHAR_DOT) && ls)) begin
      cmd_o.mask[qpds_pkg::SLOT_B0] = 1'b1;
      cmd_o.b0                      = in_byte_i;
      ls                            = 1'b0;
    end else if ((in_byte_i == qpds_pkg::CHAR_DOT) && ls) begin
      cmd_o.mask[qpds_pkg::SLOT_B0] = 1'b1;
      cmd_o.mask[qpds_pkg::SLOT_B1] = 1'b1;
      cmd_o.b0                      = qpds_pkg::CHAR_DOT;
      cmd_o.b1                      = qpds_pkg::CHAR_DOT;
      ls                            = 1'b0;
    end else if ((in_byte_i == qpds_pkg::CHAR_SPACE) && !in_last_i) begin
      held_space_d = 1'b1;
    end else if (in_byte_i == qpds_pkg::CHAR_CR) begin
      // CR is dropped
    end else if (in_byte_i == qpds_pkg::CHAR_LF) begin
      cmd_o.mask[qpds_pkg::SLOT_B0] = 1'b1;
      cmd_o.mask[qpds_pkg::SLOT_B1] = 1'b1;
      cmd_o.b0                      = qpds_pkg::CHAR_CR;
      cmd_o.b1                      = qpds_pkg::CHAR_LF;
      ls                            = 1'b1;
    end else begin
      cmd_o.mask[qpds_pkg::SLOT_B0] = 1'b1;
      cmd_o.mask[qpds_pkg::SLOT_B1] = 1'b1;
      cmd_o.mask[qpds_pkg::SLOT_B2] = 1'b1;
      cmd_o.b0                      = qpds_pkg::CHAR_EQ;
      cmd_o.b1                      = qpds_pkg::hex_char(in_byte_i[7:4]);
      cmd_o.b2                      = qpds_pkg::hex_char(in_byte_i[3:0]);
    end

    if (in_last_i) begin
      if (!ls) begin
        cmd_o.mask[qpds_pkg::SLOT_CR] = 1'b1;
        cmd_o.mask[qpds_pkg::SLOT_LF] = 1'b1;
      end
      ls           = 1'b1;
      held_space_d = 1'b0;
    end

    line_start_d = ls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_start_q <= 1'b1;
      held_space_q <= 1'b0;
    end else if (accept) begin
      line_start_q <= line_start_d;
      held_space_q <= held_space_d;
    end
  end

endmodule

@@ hdl/qpds_back.sv @@
`timescale 1ns / 1ps

module qpds_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  qpds_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);

  qpds_pkg::cmd_t                 cur_q, cur_d;
  qpds_pkg::cmd_t                 src;
  logic                           use_cur, src_ok, adv, fire;
  logic [qpds_pkg::NUM_SLOTS-1:0] low_bit, rem;
  logic [7:0]                     sel_byte;
  logic                           out_valid_q, out_valid_d;
  logic [7:0]                     out_byte_q, out_byte_d;
  logic                           out_last_q, out_last_d;

  function automatic logic [7:0] slot_byte(input int k, input qpds_pkg::cmd_t c);
    logic [7:0] r;
    case (k)
      qpds_pkg::SLOT_SP:    r = c.sp_hex ? qpds_pkg::CHAR_EQ : qpds_pkg::CHAR_SPACE;
      qpds_pkg::SLOT_SP_HI: r = qpds_pkg::CHAR_TWO;
      qpds_pkg::SLOT_SP_LO: r = qpds_pkg::CHAR_ZERO;
      qpds_pkg::SLOT_B0:    r = c.b0;
      qpds_pkg::SLOT_B1:    r = c.b1;
      qpds_pkg::SLOT_B2:    r = c.b2;
      qpds_pkg::SLOT_CR:    r = qpds_pkg::CHAR_CR;
      qpds_pkg::SLOT_LF:    r = qpds_pkg::CHAR_LF;
      default:              r = '0;
    endcase
    return r;
  endfunction

  assign use_cur = (cur_q.mask != '0);
  assign src     = use_cur ? cur_q : cmd_i;
  assign src_ok  = use_cur || cmd_valid_i;
  assign adv     = !out_valid_q || !out_stall_i;
  assign fire    = adv && src_ok;
  assign pop_o   = fire && !use_cur;

  // lowest pending slot goes out next
  assign low_bit = src.mask & (~src.mask + 1'b1);
  assign rem     = src.mask & ~low_bit;

  always_comb begin
    sel_byte = '0;
    for (int k = 0; k < qpds_pkg::NUM_SLOTS; k++) begin
      if (low_bit[k]) begin
        sel_byte = slot_byte(k, src);
      end
    end
  end

  always_comb begin
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (fire) begin
      cur_d      = src;
      cur_d.mask = rem;
    end
    if (adv) begin
      out_valid_d = src_ok;
      out_byte_d  = sel_byte;
      out_last_d  = (rem == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q   <= out_byte_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

@@ hdl/quoted_printable_dot_stuff_encoder.sv @@
`timescale 1ns / 1ps
// Quoted-printable body encoder with dot stuffing for mail transfer.
// Input channel: one raw body byte per word (in_byte_i), in_last_i on the
// final byte of a body. Output channel: encoded bytes, out_last_o on the last
// byte that an input word causes. Both channels use valid/stall; a word moves
// on an edge where valid is high and stall is low.
// A word may cause 0 to 6 output bytes. A space that is not the last byte of a
// body is held until the next byte arrives, so its bytes leave with that next word.
// Path: an accepted word that causes output is written to the command queue;
// the back end then loads its bytes, lowest slot first, into the output register.
// Throughput: the back end emits one byte per cycle while commands are queued and
// the receiver does not stall; a word produces 1 byte for plain text, 3 for an
// escape, up to 6, and none for a word that produces nothing;
// the input side keeps accepting while the command queue has room.
// Reset: line-start set, no space held, queue and output register empty.
// When the receiver stalls, the output word holds, the queue fills and
// in_stall_o rises once it is full.

module quoted_printable_dot_stuff_encoder #(
  parameter int FifoDepth = qpds_pkg::FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  qpds_pkg::cmd_t push_cmd, head_cmd;
  logic           push, full, head_valid, pop;

  qpds_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  qpds_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_cmd)
  );

  qpds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

@@ hdl/qpds_checker.sv @@
`timescale 1ns / 1ps

module qpds_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  // nothing leaves while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(out_last_o))
    else $error("stalled output word changed");

  // '=' always has two hex digits after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_byte_o == qpds_pkg::CHAR_EQ) |-> !out_last_o)
    else $error("escape marker ends a word group");

  // CR is always followed by LF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_byte_o == qpds_pkg::CHAR_CR) |-> !out_last_o)
    else $error("CR ends a word group");

endmodule

bind quoted_printable_dot_stuff_encoder qpds_checker u_qpds_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 20;
  localparam int MaxReported = 10;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } qp_byte_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       in_last_i   = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  // encoder state as predicted
  logic       line_start_q = 1'b1;
  logic       held_space_q = 1'b0;
  qp_byte_t   pending_qp_bytes[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // sender idling: bursts of words separated by idle gaps bounded by gap_max
  int unsigned gap_max    = 0;
  int unsigned burst_left = 0;
  // receiver stalling
  int unsigned stall_pct  = 0;
  int unsigned stall_run  = 0;

  quoted_printable_dot_stuff_encoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
               pending_qp_bytes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    hex_ascii = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h41 + {4'h0, nib} - 8'd10);
  endfunction

  function automatic void encode_body_byte(input logic [7:0] b, input logic last);
    logic [7:0] outb[$];
    qp_byte_t   item;
    if (held_space_q) begin
      if (b == qpds_pkg::CHAR_CR || b == qpds_pkg::CHAR_LF) begin
        outb = {outb, qpds_pkg::CHAR_EQ};
        outb = {outb, hex_ascii(qpds_pkg::CHAR_SPACE[7:4])};
        outb = {outb, hex_ascii(qpds_pkg::CHAR_SPACE[3:0])};
      end else begin
        outb = {outb, qpds_pkg::CHAR_SPACE};
        line_start_q = 1'b0;
      end
      held_space_q = 1'b0;
    end
    if (b >= qpds_pkg::PRINT_LO && b <= qpds_pkg::PRINT_HI && b != qpds_pkg::CHAR_EQ
        && (b != qpds_pkg::CHAR_DOT || !line_start_q)) begin
      outb = {outb, b};
      line_start_q = 1'b0;
    end else if (b == qpds_pkg::CHAR_DOT && line_start_q) begin
      outb = {outb, qpds_pkg::CHAR_DOT};
      outb = {outb, qpds_pkg::CHAR_DOT};
      line_start_q = 1'b0;
    end else if (b == qpds_pkg::CHAR_SPACE && !last) begin
      held_space_q = 1'b1;
    end else if (b == qpds_pkg::CHAR_CR) begin
      // CR is dropped
    end else if (b == qpds_pkg::CHAR_LF) begin
      outb = {outb, qpds_pkg::CHAR_CR};
      outb = {outb, qpds_pkg::CHAR_LF};
      line_start_q = 1'b1;
    end else begin
      outb = {outb, qpds_pkg::CHAR_EQ};
      outb = {outb, hex_ascii(b[7:4])};
      outb = {outb, hex_ascii(b[3:0])};
    end
    if (last) begin
      if (!line_start_q) begin
        outb = {outb, qpds_pkg::CHAR_CR};
        outb = {outb, qpds_pkg::CHAR_LF};
      end
      line_start_q = 1'b1;
      held_space_q = 1'b0;
    end
    foreach (outb[k]) begin
      item.data        = outb[k];
      item.last        = (k == outb.size() - 1);
      pending_qp_bytes = {pending_qp_bytes, item};
    end
  endfunction

  // Drive one word and hold it until accepted; valid stays high afterwards.
  task automatic send_word(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    encode_body_byte(b, last);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run   <= stall_run - 1;
      out_stall_i <= 1'b1;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      out_stall_i <= 1'b1;
      if ($urandom_range(31) == 0) stall_run <= $urandom_range(5, 20);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // output word check against the oldest prediction
  always @(posedge clk_i) begin
    qp_byte_t exp_b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_qp_bytes.size() == 0) begin
        error_count++;
        if (error_count <= MaxReported)
          $display("unexpected output word: byte %02h last %0b", out_byte_o, out_last_o);
      end else begin
        exp_b = pending_qp_bytes.pop_front();
        if (out_byte_o !== exp_b.data || out_last_o !== exp_b.last) begin
          error_count++;
          if (error_count <= MaxReported)
            $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     exp_b.data, exp_b.last, out_byte_o, out_last_o);
        end
      end
    end
  end

  task automatic test_escapes_and_extremes();
    gap_max   = 0;
    stall_pct = 0;
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(qpds_pkg::CHAR_EQ, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(qpds_pkg::PRINT_LO, 1'b0);
    send_word(qpds_pkg::PRINT_HI, 1'b0);
    send_word(qpds_pkg::CHAR_DOT, 1'b1);   // mid-line dot, body ends with CRLF
  endtask

  task automatic test_dot_stuffing();
    gap_max   = 3;
    stall_pct = 20;
    send_word(qpds_pkg::CHAR_DOT, 1'b0);   // line start: doubled
    send_word(qpds_pkg::CHAR_LF, 1'b0);
    send_word(qpds_pkg::CHAR_DOT, 1'b1);   // doubled, then CRLF
  endtask

  task automatic test_held_space();
    gap_max   = 2;
    stall_pct = 40;
    send_word(qpds_pkg::CHAR_SPACE, 1'b0);
    send_word(qpds_pkg::CHAR_DOT, 1'b0);   // plain space ends line start, dot not doubled
    send_word(qpds_pkg::CHAR_SPACE, 1'b0);
    send_word(qpds_pkg::CHAR_CR, 1'b0);    // space before CR goes out escaped
    send_word(qpds_pkg::CHAR_LF, 1'b0);
    send_word(qpds_pkg::CHAR_SPACE, 1'b0);
    send_word(qpds_pkg::CHAR_LF, 1'b0);
    send_word(qpds_pkg::CHAR_SPACE, 1'b0);
    send_word(qpds_pkg::CHAR_SPACE, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(qpds_pkg::CHAR_SPACE, 1'b1); // trailing space on last byte
    send_word(qpds_pkg::CHAR_SPACE, 1'b1); // lone space body at line start
    send_word(qpds_pkg::CHAR_CR, 1'b1);    // lone CR body: no output at all
    send_word(qpds_pkg::CHAR_SPACE, 1'b0);
    send_word(qpds_pkg::CHAR_CR, 1'b1);
    send_word(qpds_pkg::CHAR_SPACE, 1'b0);
    send_word(qpds_pkg::CHAR_EQ, 1'b1);
  endtask

  task automatic test_random_mail_text(input int unsigned n_words);
    int unsigned sent;
    int unsigned body_len;
    int unsigned sel;
    logic [7:0]  b;
    sent = 0;
    while (sent < n_words) begin
      body_len = $urandom_range(1, 30);
      case ($urandom_range(3))
        0: begin gap_max = 0; stall_pct = 0; end
        1: begin gap_max = 4; stall_pct = 25; end
        2: begin gap_max = 10; stall_pct = 60; end
        default: begin gap_max = 1; stall_pct = 80; end
      endcase
      for (int i = 0; i < body_len; i++) begin
        sel = $urandom_range(99);
        if (sel < 55)      b = 8'(8'h61 + $urandom_range(25));
        else if (sel < 68) b = qpds_pkg::CHAR_SPACE;
        else if (sel < 75) b = qpds_pkg::CHAR_DOT;
        else if (sel < 83) begin
          send_word(qpds_pkg::CHAR_CR, 1'b0);
          sent++;
          b = qpds_pkg::CHAR_LF;
        end
        else if (sel < 88) b = qpds_pkg::CHAR_LF;
        else if (sel < 92) b = qpds_pkg::CHAR_EQ;
        else               b = 8'($urandom_range(255));
        send_word(b, i == body_len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_random_noise(input int unsigned n_words);
    gap_max   = 6;
    stall_pct = 35;
    for (int i = 0; i < n_words; i++) begin
      if (i % 25 == 0) begin
        gap_max   = $urandom_range(0, 8);
        stall_pct = $urandom_range(0, 70);
      end
      send_word(8'($urandom_range(255)), $urandom_range(15) == 0);
    end
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_escapes_and_extremes();
    test_dot_stuffing();
    test_held_space();
    test_random_mail_text(140);
    test_random_noise(100);

    in_valid_i <= 1'b0;
    while (pending_qp_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0 && pending_qp_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/qpds_pkg.sv
hdl/qpds_fifo.sv
hdl/qpds_front.sv
hdl/qpds_back.sv
hdl/quoted_printable_dot_stuff_encoder.sv
hdl/qpds_checker.sv
dv/testbench.sv
